[rtl/c_syntax_highlight_classifier_defines.svh]
// Assertion macros used by the syntax highlight classifier top level.
`ifndef C_SYNTAX_HIGHLIGHT_CLASSIFIER_DEFINES_SVH
`define C_SYNTAX_HIGHLIGHT_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clk edge out of reset.
`define CHL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("classifier assertion failed");
// Next-cycle implication.
`define CHL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("classifier assertion failed");
`else
`define CHL_ASSERT_NOW(label, ante, cons)
`define CHL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/chl_pkg.sv]
// Shared types, constants and keyword tables of the syntax highlight classifier.
package chl_pkg;

	localparam int LOOKAHEAD_DEF = 9;
	localparam int NUM_WORDS     = 23;
	localparam int MAX_WORD_LEN  = 8;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [2:0] {
		CLS_NORMAL,
		CLS_COMMENT,
		CLS_KEYWORD,
		CLS_DATATYPE,
		CLS_NUMBER
	} cls_t;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBERS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMENTS  = 2'd2;

	localparam logic [6:0] COLOR_NORMAL   = 7'd37;
	localparam logic [6:0] COLOR_COMMENT  = 7'd32;
	localparam logic [6:0] COLOR_KEYWORD  = 7'd95;
	localparam logic [6:0] COLOR_DATATYPE = 7'd34;
	localparam logic [6:0] COLOR_NUMBER   = 7'd33;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Status of the lookahead window handed to the top level.
	typedef struct packed {
		logic can_emit;
		logic last;
		logic flush;
	} win_stat_t;

	function automatic logic is_sep(input logic [7:0] c);
		case (c)
			8'h00, 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
			8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A,
			8'h3D, 8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [6:0] color_of(input cls_t cls);
		case (cls)
			CLS_COMMENT:  return COLOR_COMMENT;
			CLS_KEYWORD:  return COLOR_KEYWORD;
			CLS_DATATYPE: return COLOR_DATATYPE;
			CLS_NUMBER:   return COLOR_NUMBER;
			default:      return COLOR_NORMAL;
		endcase
	endfunction

	// Word text right aligned: first character in the highest used byte.
	function automatic logic [8*MAX_WORD_LEN-1:0] word_text(input int k);
		case (k)
			0:  return "switch";
			1:  return "if";
			2:  return "while";
			3:  return "for";
			4:  return "break";
			5:  return "continue";
			6:  return "return";
			7:  return "else";
			8:  return "struct";
			9:  return "union";
			10: return "typedef";
			11: return "static";
			12: return "enum";
			13: return "class";
			14: return "case";
			15: return "int";
			16: return "long";
			17: return "double";
			18: return "float";
			19: return "char";
			20: return "unsigned";
			21: return "signed";
			22: return "void";
			default: return '0;
		endcase
	endfunction

	function automatic logic [3:0] word_len(input int k);
		case (k)
			1:                   return 4'd2;
			3, 15:               return 4'd3;
			7, 12, 14, 16, 19, 22: return 4'd4;
			2, 4, 9, 13, 18:     return 4'd5;
			0, 6, 8, 11, 17, 21: return 4'd6;
			10:                  return 4'd7;
			5, 20:               return 4'd8;
			default:             return 4'd0;
		endcase
	endfunction

	function automatic cls_t word_cls(input int k);
		return (k >= 15) ? CLS_DATATYPE : CLS_KEYWORD;
	endfunction

	function automatic logic [7:0] word_char(input int k, input int m);
		logic [8*MAX_WORD_LEN-1:0] text;
		int len;
		text = word_text(k);
		len = int'(word_len(k));
		if (m >= len)
			return 8'h00;
		return text[8*(len-1-m) +: 8];
	endfunction

endpackage

[rtl/c_syntax_highlight_classifier.sv]
// Mid-row a character's result leaves the window LOOKAHEAD-1 characters later, then passes
// through the output register. Throughput: one character per cycle within a row while out_stall is low.
// On the row's last character the window drains one result per cycle while out_stall is low;
// input is held until the drain has emptied the window (at most LOOKAHEAD characters).
// The window fill and the single output register set this behaviour.
// Reset (arst_n low, asynchronous): empty window, row state cleared, all enables on.
`include "c_syntax_highlight_classifier_defines.svh"

module c_syntax_highlight_classifier #(
	parameter int LOOKAHEAD = chl_pkg::LOOKAHEAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input transaction: one character of the row
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    char_in,
	input  logic                          row_end,
	// output transaction: one classified character
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    char_out,
	output logic [2:0]                    hl_class,
	output logic [6:0]                    color_code,
	output logic                          last_of_row,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [chl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [0:0]                    cfg_data
);

	localparam int CW = $clog2(LOOKAHEAD + 1);

	logic               highlight_en_q;
	logic               numbers_en_q;
	logic               comments_en_q;

	logic [7:0]         win [LOOKAHEAD];
	logic [CW-1:0]      avail;
	chl_pkg::win_stat_t stat;
	chl_pkg::cls_t      cls;
	chl_pkg::cls_t      shown;
	logic               emit;
	logic               row_done;

	logic               out_valid_q;
	logic [7:0]         char_out_q;
	chl_pkg::cls_t      hl_class_q;
	logic [6:0]         color_code_q;
	logic               last_of_row_q;

	// Configuration registers: index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highlight_en_q <= 1'b1;
			numbers_en_q   <= 1'b1;
			comments_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				chl_pkg::CFG_HIGHLIGHT: highlight_en_q <= cfg_data[0];
				chl_pkg::CFG_NUMBERS:   numbers_en_q   <= cfg_data[0];
				chl_pkg::CFG_COMMENTS:  comments_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the head whenever the window offers one and the output register frees up;
	// the output register may be refilled in the cycle its transaction completes.
	assign emit     = stat.can_emit && (!out_valid_q || !out_stall);
	assign row_done = emit && stat.last;

	chl_window #(
		.LOOKAHEAD(LOOKAHEAD)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.char_in  (char_in),
		.row_end  (row_end),
		.emit     (emit),
		.win      (win),
		.avail    (avail),
		.stat     (stat)
	);

	chl_classify #(
		.LOOKAHEAD(LOOKAHEAD)
	) u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.win         (win),
		.avail       (avail),
		.step        (emit),
		.row_done    (row_done),
		.numbers_en  (numbers_en_q),
		.comments_en (comments_en_q),
		.cls         (cls)
	);

	// With highlighting off the row state still runs; only the shown class drops to normal.
	assign shown = highlight_en_q ? cls : chl_pkg::CLS_NORMAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_out_q    <= win[0];
			hl_class_q    <= shown;
			color_code_q  <= chl_pkg::color_of(shown);
			last_of_row_q <= stat.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = char_out_q;
	assign hl_class    = hl_class_q;
	assign color_code  = color_code_q;
	assign last_of_row = last_of_row_q;

	// The row drain ends with an empty window and the window never overfills.
	`CHL_ASSERT_NEXT(a_drain_empties, row_done, (avail == '0) && !stat.flush)
	`CHL_ASSERT_NOW(a_window_bound, 1'b1, avail <= CW'(LOOKAHEAD))
	// Normal class and the normal color go together on every valid result.
	`CHL_ASSERT_NOW(a_color_match, out_valid_q,
		(hl_class_q == chl_pkg::CLS_NORMAL) == (color_code_q == chl_pkg::COLOR_NORMAL))

endmodule

[rtl/chl_window.sv]
// Lookahead window: character shift register, fill count and row flush control.
module chl_window #(
	parameter int LOOKAHEAD = chl_pkg::LOOKAHEAD_DEF,
	localparam int CW = $clog2(LOOKAHEAD + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_in,
	input  logic               row_end,
	input  logic               emit,
	output logic [7:0]         win [LOOKAHEAD],
	output logic [CW-1:0]      avail,
	output chl_pkg::win_stat_t stat
);

	logic [7:0]    win_q [LOOKAHEAD];
	logic [CW-1:0] cnt_q;
	logic          flush_q;
	logic          accept;
	logic [CW-1:0] cnt_after;

	assign win   = win_q;
	assign avail = cnt_q;

	assign stat.flush    = flush_q;
	assign stat.can_emit = flush_q || (cnt_q == CW'(LOOKAHEAD));
	assign stat.last     = flush_q && (cnt_q == CW'(1));

	// Hold input during a row drain, and when full with no head leaving.
	assign in_stall  = flush_q || ((cnt_q == CW'(LOOKAHEAD)) && !emit);
	assign accept    = in_valid && !in_stall;
	assign cnt_after = cnt_q - CW'(emit);

	always_ff @(posedge clk) begin
		for (int i = 0; i < LOOKAHEAD; i++) begin
			if (accept && (CW'(i) == cnt_after)) begin
				win_q[i] <= char_in;
			end else if (emit && (i + 1 < LOOKAHEAD)) begin
				win_q[i] <= win_q[(i + 1) % LOOKAHEAD];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			flush_q <= 1'b0;
		end else begin
			cnt_q <= cnt_after + CW'(accept);
			if (accept && row_end) begin
				flush_q <= 1'b1;
			end else if (emit && stat.last) begin
				flush_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/chl_classify.sv]
// Head-of-window classifier: comment, number and keyword decisions plus row state.
module chl_classify #(
	parameter int LOOKAHEAD = chl_pkg::LOOKAHEAD_DEF,
	localparam int CW = $clog2(LOOKAHEAD + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    win [LOOKAHEAD],
	input  logic [CW-1:0] avail,
	input  logic          step,
	input  logic          row_done,
	input  logic          numbers_en,
	input  logic          comments_en,
	output chl_pkg::cls_t cls
);

	logic          after_sep_q, after_sep_n;
	chl_pkg::cls_t prev_cls_q;
	logic          in_comment_q, in_comment_n;
	logic [3:0]    pend_cnt_q, pend_cnt_n;
	chl_pkg::cls_t pend_cls_q, pend_cls_n;

	logic          hit;
	chl_pkg::cls_t hit_cls;
	logic [3:0]    hit_len;
	logic          digit;

	// Match every word in parallel; the earliest word in the list wins.
	always_comb begin
		logic [chl_pkg::NUM_WORDS-1:0] match;
		logic same;
		logic follow;
		match   = '0;
		for (int k = 0; k < chl_pkg::NUM_WORDS; k++) begin
			same = (CW'(chl_pkg::word_len(k)) <= avail);
			for (int m = 0; m < chl_pkg::MAX_WORD_LEN; m++) begin
				if ((m < int'(chl_pkg::word_len(k))) && (win[m] != chl_pkg::word_char(k, m)))
					same = 1'b0;
			end
			// End of row counts as the separator after the word.
			follow = (CW'(chl_pkg::word_len(k)) == avail);
			for (int j = 1; j <= chl_pkg::MAX_WORD_LEN; j++) begin
				if ((j == int'(chl_pkg::word_len(k))) && chl_pkg::is_sep(win[j]))
					follow = 1'b1;
			end
			match[k] = same && follow;
		end
		hit     = 1'b0;
		hit_cls = chl_pkg::CLS_NORMAL;
		hit_len = '0;
		for (int k = chl_pkg::NUM_WORDS - 1; k >= 0; k--) begin
			if (match[k]) begin
				hit     = 1'b1;
				hit_cls = chl_pkg::word_cls(k);
				hit_len = chl_pkg::word_len(k);
			end
		end
	end

	assign digit = (win[0] >= chl_pkg::CH_ZERO) && (win[0] <= chl_pkg::CH_NINE);

	always_comb begin
		cls          = chl_pkg::CLS_NORMAL;
		after_sep_n  = after_sep_q;
		in_comment_n = in_comment_q;
		pend_cnt_n   = pend_cnt_q;
		pend_cls_n   = pend_cls_q;
		if (pend_cnt_q != 4'd0) begin
			cls        = pend_cls_q;
			pend_cnt_n = pend_cnt_q - 4'd1;
		end else if (in_comment_q) begin
			cls = chl_pkg::CLS_COMMENT;
		end else if (comments_en && (win[0] == chl_pkg::CH_SLASH) && (avail > CW'(1))
				&& (win[1] == chl_pkg::CH_SLASH)) begin
			in_comment_n = 1'b1;
			cls          = chl_pkg::CLS_COMMENT;
		end else if (numbers_en && ((digit && (after_sep_q || prev_cls_q == chl_pkg::CLS_NUMBER))
				|| ((win[0] == chl_pkg::CH_DOT) && prev_cls_q == chl_pkg::CLS_NUMBER))) begin
			cls         = chl_pkg::CLS_NUMBER;
			after_sep_n = 1'b0;
		end else if (after_sep_q && hit) begin
			cls         = hit_cls;
			pend_cls_n  = hit_cls;
			pend_cnt_n  = hit_len - 4'd1;
			after_sep_n = 1'b0;
		end else begin
			after_sep_n = chl_pkg::is_sep(win[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_sep_q  <= 1'b1;
			prev_cls_q   <= chl_pkg::CLS_NORMAL;
			in_comment_q <= 1'b0;
			pend_cnt_q   <= '0;
			pend_cls_q   <= chl_pkg::CLS_NORMAL;
		end else if (step) begin
			if (row_done) begin
				after_sep_q  <= 1'b1;
				prev_cls_q   <= chl_pkg::CLS_NORMAL;
				in_comment_q <= 1'b0;
				pend_cnt_q   <= '0;
				pend_cls_q   <= chl_pkg::CLS_NORMAL;
			end else begin
				after_sep_q  <= after_sep_n;
				prev_cls_q   <= cls;
				in_comment_q <= in_comment_n;
				pend_cnt_q   <= pend_cnt_n;
				pend_cls_q   <= pend_cls_n;
			end
		end
	end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the C syntax highlight classifier: directed rows, then random rows.
`timescale 1ns / 1ps

module tb_top;

	localparam int LOOKAHEAD = chl_pkg::LOOKAHEAD_DEF;
	// Cycles with no transaction on either side before the run is declared hung.
	localparam int STALL_LIMIT = 1000;
	// Length of the long receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 48;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 10;
	// Index past the last register; the block must ignore writes to it.
	localparam logic [chl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

	// One classified character as the block should return it.
	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] cls;
		logic [6:0] color;
		logic       last;
	} glyph_t;

	// One directed character; typed rows carry their class, the rest go to the predictor.
	typedef struct packed {
		logic [7:0]    ch;
		logic          last;
		logic          typed;
		chl_pkg::cls_t cls;
	} stim_char_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [7:0]                    char_in = 8'h00;
	logic                          row_end = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [7:0]                    char_out;
	logic [2:0]                    hl_class;
	logic [6:0]                    color_code;
	logic                          last_of_row;
	logic                          cfg_we = 1'b0;
	logic [chl_pkg::CFG_IDX_W-1:0] cfg_index = chl_pkg::CFG_HIGHLIGHT;
	logic [0:0]                    cfg_data = 1'b0;

	always #2 clk = ~clk;

	c_syntax_highlight_classifier #(
		.LOOKAHEAD(LOOKAHEAD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.row_end(row_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_out(char_out),
		.hl_class(hl_class),
		.color_code(color_code),
		.last_of_row(last_of_row),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Keywords first, data types from index 15 on; the first match in this order wins.
	string c_words [chl_pkg::NUM_WORDS] = '{
		"switch", "if", "while", "for", "break", "continue", "return", "else",
		"struct", "union", "typedef", "static", "enum", "class", "case",
		"int", "long", "double", "float", "char", "unsigned", "signed", "void"
	};
	string sep_marks = ",.()+-/*=~%<>[];";

	// Shadow of the registers and the row state of the classifier.
	logic          hl_on = 1'b1;
	logic          num_on = 1'b1;
	logic          cmt_on = 1'b1;
	logic [7:0]    win [LOOKAHEAD];
	int            win_n = 0;
	logic          after_sep = 1'b1;
	chl_pkg::cls_t prev_cls = chl_pkg::CLS_NORMAL;
	logic          in_cmt = 1'b0;
	int            mark_left = 0;
	chl_pkg::cls_t mark_cls = chl_pkg::CLS_NORMAL;

	glyph_t     glyphs_due [$];
	logic [7:0] row_text [$];
	int         fails = 0;
	idle_t      idle_mode = IDLE_NONE;
	logic       hold_req = 1'b0;
	int         hold_left = 0;

	// Directed rows: short keyword, comment, number run with a dot, data type,
	// the byte extremes, then a keyword prefix that is no keyword and a row
	// longer than the window that ends in one of the longest keywords.
	stim_char_t opening_rows [27] = '{
		'{"i", 1'b0, 1'b1, chl_pkg::CLS_KEYWORD},
		'{"f", 1'b1, 1'b1, chl_pkg::CLS_KEYWORD},
		'{"/", 1'b0, 1'b1, chl_pkg::CLS_COMMENT},
		'{"/", 1'b0, 1'b1, chl_pkg::CLS_COMMENT},
		'{"c", 1'b1, 1'b1, chl_pkg::CLS_COMMENT},
		'{"1", 1'b0, 1'b1, chl_pkg::CLS_NUMBER},
		'{"2", 1'b0, 1'b1, chl_pkg::CLS_NUMBER},
		'{".", 1'b0, 1'b1, chl_pkg::CLS_NUMBER},
		'{"5", 1'b0, 1'b1, chl_pkg::CLS_NUMBER},
		'{" ", 1'b1, 1'b1, chl_pkg::CLS_NORMAL},
		'{"i", 1'b0, 1'b1, chl_pkg::CLS_DATATYPE},
		'{"n", 1'b0, 1'b1, chl_pkg::CLS_DATATYPE},
		'{"t", 1'b1, 1'b1, chl_pkg::CLS_DATATYPE},
		'{8'h00, 1'b0, 1'b1, chl_pkg::CLS_NORMAL},
		'{8'hFF, 1'b1, 1'b1, chl_pkg::CLS_NORMAL},
		'{"i", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"f", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"x", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"=", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"c", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"o", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"n", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"t", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"i", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"n", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"u", 1'b0, 1'b0, chl_pkg::CLS_NORMAL},
		'{"e", 1'b1, 1'b0, chl_pkg::CLS_NORMAL}
	};

	// Register settings per random phase, as {highlight, numbers, comments}.
	logic [2:0] phase_cfg [PHASES] = '{
		3'b111, 3'b011, 3'b101, 3'b110, 3'b000, 3'b100, 3'b010, 3'b111
	};

	function automatic logic splits_word(input logic [7:0] c);
		int k;
		if (c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))
			return 1'b1;
		for (k = 0; k < sep_marks.len(); k++)
			if (c == sep_marks[k])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [6:0] shade_of(input chl_pkg::cls_t cls);
		case (cls)
			chl_pkg::CLS_COMMENT:  return chl_pkg::COLOR_COMMENT;
			chl_pkg::CLS_KEYWORD:  return chl_pkg::COLOR_KEYWORD;
			chl_pkg::CLS_DATATYPE: return chl_pkg::COLOR_DATATYPE;
			chl_pkg::CLS_NUMBER:   return chl_pkg::COLOR_NUMBER;
			default:               return chl_pkg::COLOR_NORMAL;
		endcase
	endfunction

	// Append one expected result to the tail of the queue.
	function automatic void post_glyph(input glyph_t g);
		glyphs_due = {glyphs_due, g};
	endfunction

	// Append one byte to the row under construction.
	function automatic void add_byte(input logic [7:0] b);
		row_text = {row_text, b};
	endfunction

	// Classify win[base]; n characters from base on are known, and the row
	// ends after them when n is short of the window.
	function automatic chl_pkg::cls_t classify_lead(input int base, input int n);
		logic [7:0]    c;
		chl_pkg::cls_t cls;
		logic          digit;
		logic          hit;
		logic          same;
		int            len;
		int            k;
		int            m;
		c = win[base];
		cls = chl_pkg::CLS_NORMAL;
		digit = (c >= chl_pkg::CH_ZERO && c <= chl_pkg::CH_NINE);
		if (mark_left > 0) begin
			// rest of a matched word: no other test applies
			cls = mark_cls;
			mark_left--;
		end else if (in_cmt) begin
			cls = chl_pkg::CLS_COMMENT;
		end else if (cmt_on && c == chl_pkg::CH_SLASH && n > 1
				&& win[base + 1] == chl_pkg::CH_SLASH) begin
			in_cmt = 1'b1;
			cls = chl_pkg::CLS_COMMENT;
		end else if (num_on && ((digit && (after_sep || prev_cls == chl_pkg::CLS_NUMBER)) ||
				(c == chl_pkg::CH_DOT && prev_cls == chl_pkg::CLS_NUMBER))) begin
			cls = chl_pkg::CLS_NUMBER;
			after_sep = 1'b0;
		end else begin
			hit = 1'b0;
			if (after_sep) begin
				for (k = 0; k < chl_pkg::NUM_WORDS && !hit; k++) begin
					len = c_words[k].len();
					same = (len <= n);
					for (m = 0; same && m < len; m++)
						if (win[base + m] != c_words[k][m])
							same = 1'b0;
					// the end of the row counts as a separator
					if (same && (len >= n || splits_word(win[base + len]))) begin
						hit = 1'b1;
						cls = (k >= 15) ? chl_pkg::CLS_DATATYPE : chl_pkg::CLS_KEYWORD;
						mark_cls = cls;
						mark_left = len - 1;
					end
				end
			end
			after_sep = hit ? 1'b0 : splits_word(c);
		end
		prev_cls = cls;
		return cls;
	endfunction

	function automatic void queue_glyph(input logic [7:0] c, input chl_pkg::cls_t cls,
			input logic fin);
		chl_pkg::cls_t shown;
		shown = hl_on ? cls : chl_pkg::CLS_NORMAL;
		post_glyph('{c, shown, shade_of(shown), fin});
	endfunction

	// Advance the shadow window by one accepted character and queue what leaves it.
	function automatic void take_char(input logic [7:0] c, input logic fin);
		int base;
		if (win_n >= LOOKAHEAD)
			win_n = LOOKAHEAD - 1;
		win[win_n] = c;
		win_n++;
		if (fin) begin
			// row end: flush the whole window, then clear the row state
			for (base = 0; base < win_n; base++)
				queue_glyph(win[base], classify_lead(base, win_n - base), base + 1 == win_n);
			win_n = 0;
			after_sep = 1'b1;
			prev_cls = chl_pkg::CLS_NORMAL;
			in_cmt = 1'b0;
			mark_left = 0;
			mark_cls = chl_pkg::CLS_NORMAL;
		end else if (win_n == LOOKAHEAD) begin
			queue_glyph(win[0], classify_lead(0, win_n), 1'b0);
			for (base = 0; base < LOOKAHEAD - 1; base++)
				win[base] = win[base + 1];
			win_n = LOOKAHEAD - 1;
		end
	endfunction

	function automatic int gap_rate(input logic rx);
		case (idle_mode)
			IDLE_SENDER:   return rx ? 0 : 51;
			IDLE_RECEIVER: return rx ? 51 : 0;
			IDLE_BOTH:     return 6;
			default:       return 0;
		endcase
	endfunction

	// Build one random row out of tokens: mostly words, numbers, names,
	// separators, blanks and comments, with some raw bytes as noise.
	task automatic fill_row();
		int    target;
		int    pick;
		int    k;
		string w;
		row_text.delete();
		target = ($urandom_range(7) == 0) ? int'($urandom_range(24, 10))
			: int'($urandom_range(10, 1));
		while (row_text.size() < target) begin
			pick = int'($urandom_range(99));
			if (pick < 25) begin
				w = c_words[$urandom_range(chl_pkg::NUM_WORDS - 1)];
				for (k = 0; k < w.len(); k++)
					add_byte(w[k]);
			end else if (pick < 40) begin
				for (k = int'($urandom_range(3, 1)); k > 0; k--)
					add_byte(chl_pkg::CH_ZERO + 8'($urandom_range(9)));
				if ($urandom_range(1)) begin
					add_byte(chl_pkg::CH_DOT);
					add_byte(chl_pkg::CH_ZERO + 8'($urandom_range(9)));
				end
			end else if (pick < 55) begin
				for (k = int'($urandom_range(4, 1)); k > 0; k--)
					add_byte($urandom_range(5) == 0 ? 8'h5F : 8'h61 + 8'($urandom_range(25)));
			end else if (pick < 70) begin
				add_byte(sep_marks[$urandom_range(sep_marks.len() - 1)]);
			end else if (pick < 78) begin
				add_byte(chl_pkg::CH_SLASH);
				add_byte(chl_pkg::CH_SLASH);
			end else if (pick < 90) begin
				add_byte($urandom_range(3) == 0 ? 8'h09 : 8'h20);
			end else begin
				add_byte(8'($urandom_range(255)));
			end
		end
	endtask

	// Offer one character and hold it until the transaction completes.
	task automatic offer_char(input logic [7:0] c, input logic fin, input logic typed,
			input chl_pkg::cls_t cls);
		while ($urandom_range(99) < gap_rate(1'b0)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		row_end <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (typed)
			post_glyph('{c, cls, shade_of(cls), fin});
		else
			take_char(c, fin);
	endtask

	// Drop valid and wait until every queued result has come back, then linger.
	task automatic drain(input int linger);
		in_valid <= 1'b0;
		@(posedge clk);
		while (glyphs_due.size() != 0)
			@(posedge clk);
		repeat (linger) @(posedge clk);
	endtask

	task automatic write_reg(input logic [chl_pkg::CFG_IDX_W-1:0] idx, input logic v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		case (idx)
			chl_pkg::CFG_HIGHLIGHT: hl_on = v;
			chl_pkg::CFG_NUMBERS:   num_on = v;
			chl_pkg::CFG_COMMENTS:  cmt_on = v;
			default:                ;
		endcase
	endtask

	task automatic check_glyph();
		glyph_t due;
		if (glyphs_due.size() == 0) begin
			fails++;
			$error("unexpected result: char_out %0h hl_class %0d", char_out, hl_class);
			return;
		end
		due = glyphs_due.pop_front();
		if (char_out !== due.ch) begin
			fails++;
			$error("char_out: expected %0h, got %0h", due.ch, char_out);
		end
		if (hl_class !== due.cls) begin
			fails++;
			$error("hl_class: expected %0d, got %0d", due.cls, hl_class);
		end
		if (color_code !== due.color) begin
			fails++;
			$error("color_code: expected %0d, got %0d", due.color, color_code);
		end
		if (last_of_row !== due.last) begin
			fails++;
			$error("last_of_row: expected %0b, got %0b", due.last, last_of_row);
		end
	endtask

	// Result side: check each completed transaction, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_glyph();
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < gap_rate(1'b1));
		end
	end

	// Watchdog: count cycles in which neither side completes a transaction.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("c_syntax_highlight_classifier regression: fail");
		$finish;
	end

	initial begin : stimulus
		int p;
		int k;
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write past the last register must leave every enable on.
		write_reg(CFG_UNUSED, 1'b0);
		cfg_we <= 1'b0;
		foreach (opening_rows[i])
			offer_char(opening_rows[i].ch, opening_rows[i].last, opening_rows[i].typed,
				opening_rows[i].cls);

		for (p = 0; p < PHASES; p++) begin
			// Change registers only once the block has gone idle.
			drain(LOOKAHEAD + 2);
			write_reg(chl_pkg::CFG_HIGHLIGHT, phase_cfg[p][2]);
			write_reg(chl_pkg::CFG_NUMBERS, phase_cfg[p][1]);
			write_reg(chl_pkg::CFG_COMMENTS, phase_cfg[p][0]);
			cfg_we <= 1'b0;
			idle_mode = idle_t'(p % 4);
			// Back the block up: the receiver holds off while the sender keeps offering.
			if (p == 4)
				hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				fill_row();
				for (k = 0; k < row_text.size(); k++) begin
					offer_char(row_text[k], k == row_text.size() - 1, 1'b0,
						chl_pkg::CLS_NORMAL);
					sent++;
					// Pause the sender once, possibly mid-row, until the queue empties.
					if (p == 5 && sent == 4)
						drain(0);
				end
			end
		end

		drain(LOOKAHEAD + 4);
		if (fails == 0 && glyphs_due.size() == 0)
			$display("c_syntax_highlight_classifier regression: pass");
		else
			$display("c_syntax_highlight_classifier regression: fail");
		$finish;
	end

endmodule
